### rtl/twbm_pkg.sv
// package for the two-wire byte transaction master
// phase codes, reset values, register indexes and the result record
// no dependencies
`default_nettype none

package twbm_pkg;

	localparam int HoldW = 16;
	localparam int AckW  = 8;

	localparam logic [HoldW-1:0] HOLD_TICKS_RESET  = 16'd4;
	localparam logic [AckW-1:0]  ACK_TIMEOUT_RESET = 8'd44;
	localparam logic [2:0]       BIT_MSB           = 3'd7;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_HOLD_TICKS  = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} reg_index_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_A    = 5'd1,
		PH_ST_B    = 5'd2,
		PH_ST_C    = 5'd3,
		PH_WA_SET  = 5'd4,
		PH_WA_HIGH = 5'd5,
		PH_WA_LOW  = 5'd6,
		PH_A1_WAIT = 5'd7,
		PH_A1_HIGH = 5'd8,
		PH_A1_LOW  = 5'd9,
		PH_RB_LOW  = 5'd10,
		PH_RB_MID  = 5'd11,
		PH_RB_HIGH = 5'd12,
		PH_A2_WAIT = 5'd13,
		PH_A2_HIGH = 5'd14,
		PH_A2_LOW  = 5'd15,
		PH_SP_A    = 5'd16,
		PH_SP_B    = 5'd17,
		PH_WD_SET  = 5'd18,
		PH_WD_HIGH = 5'd19,
		PH_WD_LOW  = 5'd20
	} phase_t;

	// result record, scl in the lowest bit
	typedef struct packed {
		logic       second_ack_missing;
		logic       first_ack_missing;
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl;
	} result_t;

endpackage

`default_nettype wire

### rtl/two_wire_byte_transaction_master.sv
// Two-wire byte transaction master: each accepted stream item is one tick of a
// bit-banged start / address / ack / data / ack / stop sequence, and each tick
// returns one result with the line levels and status. An item is taken every
// clock cycle; the whole tick update is one pass of next-state logic into the
// state and result registers. Results sit in a two-entry output register, so
// input stalls only when both entries are full. Depends on twbm_pkg.
`default_nettype none

module two_wire_byte_transaction_master
	import twbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// tick input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // go, addr[7:0], wdata[7:0], sda_in, zero pad
	input  wire logic        s_tuser,  // cmd
	// result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // scl, sda_out, busy_res, done_res, read_byte[7:0],
	                                   // first_ack_missing, second_ack_missing, zero pad
);

	logic [HoldW-1:0] hold_ticks_q;
	logic [AckW-1:0]  ack_timeout_q;

	phase_t           phase_q, n_phase;
	logic [2:0]       bit_index_q, n_bit_index;
	logic [HoldW-1:0] hold_count_q, n_hold_count;
	logic [AckW-1:0]  ack_count_q, n_ack_count;
	logic [7:0]       shift_byte_q, n_shift_byte;
	logic [7:0]       saved_data_q, n_saved_data;
	logic             is_read_q, n_is_read;
	logic [1:0]       ack_flags_q, n_ack_flags;

	result_t          out_q, skid_q, res;
	logic             out_valid_q, skid_valid_q;

	logic             go, cmd, sda_in;
	logic [7:0]       addr, wdata;
	logic             accept, cfg_wr;
	logic [HoldW-1:0] eff_hold;
	logic [AckW-1:0]  ack_dec;
	logic             done, ack_phase, bit_val;
	reg_index_t       cfg_idx;

	assign go     = s_tdata[0];
	assign addr   = s_tdata[8:1];
	assign wdata  = s_tdata[16:9];
	assign sda_in = s_tdata[17];
	assign cmd    = s_tuser;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

	// configuration
	assign pready  = 1'b1;
	assign cfg_idx = reg_index_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (cfg_idx)
			REG_HOLD_TICKS:  prdata = {16'd0, hold_ticks_q};
			REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q  <= HOLD_TICKS_RESET;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_HOLD_TICKS:  hold_ticks_q  <= pwdata[HoldW-1:0];
				REG_ACK_TIMEOUT: ack_timeout_q <= pwdata[AckW-1:0];
				default: ;
			endcase
		end
	end

	// tick update
	assign eff_hold  = (hold_ticks_q == '0) ? HoldW'(1) : hold_ticks_q;
	assign ack_dec   = ack_count_q - AckW'(1);
	assign ack_phase = (phase_q == PH_A1_WAIT) || (phase_q == PH_A2_WAIT);

	always_comb begin
		n_phase      = phase_q;
		n_bit_index  = bit_index_q;
		n_hold_count = hold_count_q;
		n_ack_count  = ack_count_q;
		n_shift_byte = shift_byte_q;
		n_saved_data = saved_data_q;
		n_is_read    = is_read_q;
		n_ack_flags  = ack_flags_q;
		done         = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (go) begin
				n_is_read    = cmd;
				n_shift_byte = addr;
				n_saved_data = cmd ? 8'd0 : wdata;
				n_ack_flags  = 2'b00;
				n_bit_index  = BIT_MSB;
				n_phase      = PH_ST_A;
				n_hold_count = eff_hold;
			end
		end else if (ack_phase) begin
			if (hold_count_q != '0) begin
				n_hold_count = hold_count_q - HoldW'(1);
			end else if (!sda_in) begin
				n_phase      = (phase_q == PH_A1_WAIT) ? PH_A1_HIGH : PH_A2_HIGH;
				n_hold_count = eff_hold;
			end else begin
				n_ack_count = ack_dec;
				if (ack_dec == '0) begin
					if (phase_q == PH_A1_WAIT) begin
						n_ack_flags[0] = 1'b1;
						n_phase        = PH_A1_HIGH;
					end else begin
						n_ack_flags[1] = 1'b1;
						n_phase        = PH_A2_HIGH;
					end
					n_hold_count = eff_hold;
				end else begin
					n_hold_count = eff_hold - HoldW'(1);
				end
			end
		end else if (hold_count_q > HoldW'(1)) begin
			n_hold_count = hold_count_q - HoldW'(1);
		end else begin
			n_hold_count = eff_hold;
			unique case (phase_q)
				PH_ST_A:    n_phase = PH_ST_B;
				PH_ST_B:    n_phase = PH_ST_C;
				PH_ST_C: begin
					n_bit_index = BIT_MSB;
					n_phase     = PH_WA_SET;
				end
				PH_WA_SET:  n_phase = PH_WA_HIGH;
				PH_WA_HIGH: n_phase = PH_WA_LOW;
				PH_WA_LOW: begin
					if (bit_index_q == '0) begin
						n_phase      = PH_A1_WAIT;
						n_hold_count = '0;
						n_ack_count  = ack_timeout_q;
					end else begin
						n_bit_index = bit_index_q - 3'd1;
						n_phase     = PH_WA_SET;
					end
				end
				PH_A1_HIGH: n_phase = PH_A1_LOW;
				PH_A1_LOW: begin
					n_bit_index = BIT_MSB;
					if (is_read_q) begin
						n_phase = PH_RB_LOW;
					end else begin
						n_shift_byte = saved_data_q;
						n_phase      = PH_WD_SET;
					end
				end
				PH_WD_SET:  n_phase = PH_WD_HIGH;
				PH_WD_HIGH: n_phase = PH_WD_LOW;
				PH_WD_LOW, PH_RB_HIGH: begin
					if (bit_index_q == '0) begin
						n_phase      = PH_A2_WAIT;
						n_hold_count = '0;
						n_ack_count  = ack_timeout_q;
					end else begin
						n_bit_index = bit_index_q - 3'd1;
						n_phase     = (phase_q == PH_WD_LOW) ? PH_WD_SET : PH_RB_LOW;
					end
				end
				PH_RB_LOW: begin
					n_saved_data = {saved_data_q[6:0], sda_in};
					n_phase      = PH_RB_MID;
				end
				PH_RB_MID:  n_phase = PH_RB_HIGH;
				PH_A2_HIGH: n_phase = PH_A2_LOW;
				PH_A2_LOW:  n_phase = PH_SP_A;
				PH_SP_A:    n_phase = PH_SP_B;
				PH_SP_B: begin
					n_phase      = PH_IDLE;
					n_hold_count = '0;
					done         = 1'b1;
				end
				default: begin
					n_phase      = PH_IDLE;
					n_hold_count = '0;
				end
			endcase
		end
	end

	// line levels from the updated state
	assign bit_val = n_shift_byte[n_bit_index];

	always_comb begin
		res                    = '0;
		res.scl                = 1'b1;
		res.sda_out            = 1'b1;
		res.busy_res           = (n_phase != PH_IDLE);
		res.done_res           = done;
		res.read_byte          = n_is_read ? n_saved_data : 8'd0;
		res.first_ack_missing  = n_ack_flags[0];
		res.second_ack_missing = n_ack_flags[1];
		unique case (n_phase)
			PH_ST_B: res.sda_out = 1'b0;
			PH_ST_C: begin
				res.scl     = 1'b0;
				res.sda_out = 1'b0;
			end
			PH_WA_SET, PH_WD_SET, PH_WA_LOW, PH_WD_LOW: begin
				res.scl     = 1'b0;
				res.sda_out = bit_val;
			end
			PH_WA_HIGH, PH_WD_HIGH: res.sda_out = bit_val;
			PH_A1_WAIT, PH_A1_LOW, PH_A2_LOW, PH_RB_LOW, PH_RB_MID: res.scl = 1'b0;
			PH_A2_WAIT: res.scl = n_is_read;
			PH_SP_A:    res.sda_out = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_index_q  <= BIT_MSB;
			hold_count_q <= '0;
			ack_count_q  <= '0;
			shift_byte_q <= '0;
			saved_data_q <= '0;
			is_read_q    <= 1'b0;
			ack_flags_q  <= '0;
		end else if (accept) begin
			phase_q      <= n_phase;
			bit_index_q  <= n_bit_index;
			hold_count_q <= n_hold_count;
			ack_count_q  <= n_ack_count;
			shift_byte_q <= n_shift_byte;
			saved_data_q <= n_saved_data;
			is_read_q    <= n_is_read;
			ack_flags_q  <= n_ack_flags;
		end
	end

	// two-entry output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && m_tready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	// checks
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_idle_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (hold_count_q == '0))
		else $error("hold counter running while idle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.done_res) |-> !out_q.busy_res)
		else $error("done reported while still busy");

	a_done_from_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done) |=> (phase_q == PH_IDLE && $past(phase_q) == PH_SP_B))
		else $error("done outside the stop condition");

endmodule

`default_nettype wire

### tb/sv/twbm_checker.sv
// result checker for the two-wire byte transaction master testbench
// predicts the result of every accepted tick and compares it field by field
// depends on twbm_pkg
`default_nettype none

module twbm_checker
	import twbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,  // go, addr[7:0], wdata[7:0], sda_in, zero pad
	input  wire logic        s_tuser,  // cmd
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,  // scl, sda_out, busy_res, done_res, read_byte[7:0],
	                                   // first_ack_missing, second_ack_missing, zero pad
	output int               fails,
	output int               pending
);

	logic [HoldW-1:0] hold_ticks_q;
	logic [AckW-1:0]  ack_limit_q;

	phase_t     ph;
	logic [2:0] bit_idx;
	logic [15:0] hold_cnt;
	logic [7:0] poll_cnt;
	logic [7:0] shift_q;
	logic [7:0] data_q;
	logic       rd_q;
	logic [1:0] miss_q;

	result_t line_results_q[$];
	result_t want;
	result_t got;

	function automatic logic [15:0] level_ticks();
		return (hold_ticks_q == 0) ? 16'd1 : hold_ticks_q;
	endfunction

	function automatic void load_phase(phase_t p);
		ph = p;
		hold_cnt = level_ticks();
	endfunction

	function automatic void open_ack(phase_t p);
		ph = p;
		hold_cnt = 16'd0;
		poll_cnt = ack_limit_q;
	endfunction

	// one poll every level_ticks ticks, timeout when the counter counts down to zero
	function automatic void poll_ack(logic sdi, phase_t high_p, logic [1:0] flag);
		if (hold_cnt > 0) begin
			hold_cnt--;
		end else if (!sdi) begin
			load_phase(high_p);
		end else begin
			poll_cnt = poll_cnt - 8'd1;
			if (poll_cnt == 0) begin
				miss_q |= flag;
				load_phase(high_p);
			end else begin
				hold_cnt = level_ticks() - 16'd1;
			end
		end
	endfunction

	function automatic result_t advance_tick(logic go, logic cmd, logic [7:0] addr,
		logic [7:0] wdata, logic sdi);
		result_t r;
		logic    stop_done;
		logic    bitv;
		stop_done = 1'b0;
		if (ph == PH_IDLE) begin
			if (go) begin
				rd_q = cmd;
				shift_q = addr;
				data_q = cmd ? 8'h00 : wdata;
				miss_q = 2'b00;
				bit_idx = BIT_MSB;
				load_phase(PH_ST_A);
			end
		end else if (ph == PH_A1_WAIT) begin
			poll_ack(sdi, PH_A1_HIGH, 2'b01);
		end else if (ph == PH_A2_WAIT) begin
			poll_ack(sdi, PH_A2_HIGH, 2'b10);
		end else if (hold_cnt > 1) begin
			hold_cnt--;
		end else begin
			case (ph)
				PH_ST_A: load_phase(PH_ST_B);
				PH_ST_B: load_phase(PH_ST_C);
				PH_ST_C: begin
					bit_idx = BIT_MSB;
					load_phase(PH_WA_SET);
				end
				PH_WA_SET: load_phase(PH_WA_HIGH);
				PH_WA_HIGH: load_phase(PH_WA_LOW);
				PH_WA_LOW: begin
					if (bit_idx == 0) begin
						open_ack(PH_A1_WAIT);
					end else begin
						bit_idx--;
						load_phase(PH_WA_SET);
					end
				end
				PH_A1_HIGH: load_phase(PH_A1_LOW);
				PH_A1_LOW: begin
					bit_idx = BIT_MSB;
					if (rd_q) begin
						load_phase(PH_RB_LOW);
					end else begin
						shift_q = data_q;
						load_phase(PH_WD_SET);
					end
				end
				PH_WD_SET: load_phase(PH_WD_HIGH);
				PH_WD_HIGH: load_phase(PH_WD_LOW);
				PH_WD_LOW: begin
					if (bit_idx == 0) begin
						open_ack(PH_A2_WAIT);
					end else begin
						bit_idx--;
						load_phase(PH_WD_SET);
					end
				end
				PH_RB_LOW: begin
					data_q = {data_q[6:0], sdi};
					load_phase(PH_RB_MID);
				end
				PH_RB_MID: load_phase(PH_RB_HIGH);
				PH_RB_HIGH: begin
					if (bit_idx == 0) begin
						open_ack(PH_A2_WAIT);
					end else begin
						bit_idx--;
						load_phase(PH_RB_LOW);
					end
				end
				PH_A2_HIGH: load_phase(PH_A2_LOW);
				PH_A2_LOW: load_phase(PH_SP_A);
				PH_SP_A: load_phase(PH_SP_B);
				PH_SP_B: begin
					ph = PH_IDLE;
					hold_cnt = 16'd0;
					stop_done = 1'b1;
				end
				default: begin
					ph = PH_IDLE;
					hold_cnt = 16'd0;
				end
			endcase
		end

		// line levels of the new phase
		bitv = shift_q[bit_idx];
		r.scl = 1'b1;
		r.sda_out = 1'b1;
		case (ph)
			PH_ST_B: r.sda_out = 1'b0;
			PH_ST_C: begin
				r.scl = 1'b0;
				r.sda_out = 1'b0;
			end
			PH_WA_SET, PH_WD_SET, PH_WA_LOW, PH_WD_LOW: begin
				r.scl = 1'b0;
				r.sda_out = bitv;
			end
			PH_WA_HIGH, PH_WD_HIGH: r.sda_out = bitv;
			PH_A1_WAIT, PH_A1_LOW, PH_A2_LOW, PH_RB_LOW, PH_RB_MID: r.scl = 1'b0;
			PH_A2_WAIT: r.scl = rd_q;
			PH_SP_A: r.sda_out = 1'b0;
			default: ;
		endcase
		r.busy_res = (ph != PH_IDLE);
		r.done_res = stop_done;
		r.read_byte = rd_q ? data_q : 8'h00;
		r.first_ack_missing = miss_q[0];
		r.second_ack_missing = miss_q[1];
		return r;
	endfunction

	task automatic cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %0h got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q = HOLD_TICKS_RESET;
			ack_limit_q = ACK_TIMEOUT_RESET;
			ph = PH_IDLE;
			bit_idx = BIT_MSB;
			hold_cnt = 16'd0;
			poll_cnt = 8'd0;
			shift_q = 8'd0;
			data_q = 8'd0;
			rd_q = 1'b0;
			miss_q = 2'b00;
			line_results_q.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[2]))
					REG_HOLD_TICKS: hold_ticks_q = pwdata[HoldW-1:0];
					REG_ACK_TIMEOUT: ack_limit_q = pwdata[AckW-1:0];
				endcase
			end
			if (s_tvalid && s_tready) begin
				line_results_q.push_back(advance_tick(s_tdata[0], s_tuser, s_tdata[8:1],
					s_tdata[16:9], s_tdata[17]));
			end
			if (m_tvalid && m_tready) begin
				if (line_results_q.size() == 0) begin
					$error("result transaction with no tick waiting for it");
					fails++;
				end else begin
					want = line_results_q.pop_front();
					got = result_t'(m_tdata[13:0]);
					cmp_field("scl", want.scl, got.scl);
					cmp_field("sda_out", want.sda_out, got.sda_out);
					cmp_field("busy_res", want.busy_res, got.busy_res);
					cmp_field("done_res", want.done_res, got.done_res);
					cmp_field("read_byte", want.read_byte, got.read_byte);
					cmp_field("first_ack_missing", want.first_ack_missing,
						got.first_ack_missing);
					cmp_field("second_ack_missing", want.second_ack_missing,
						got.second_ack_missing);
				end
			end
			pending <= line_results_q.size();
		end
	end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// testbench top for the two-wire byte transaction master
// drives ticks, register writes and output back-pressure, gives the verdict
// depends on twbm_pkg, twbm_checker and the rtl top level
`default_nettype none

module tb_top
	import twbm_pkg::*;
();

	localparam int LIMIT      = 100000;
	localparam int LONG_STALL = 200;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // go, addr[7:0], wdata[7:0], sda_in, zero pad
	logic        s_tuser;  // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // scl, sda_out, busy_res, done_res, read_byte[7:0],
	                       // first_ack_missing, second_ack_missing, zero pad
	int          fails;
	int          pending;
	int          cycles = 0;
	bit          calm = 1'b0;
	bit          stall_req = 1'b0;

	two_wire_byte_transaction_master u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	twbm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fails(fails), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// output back-pressure
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_tick(logic go, logic cmd, logic [7:0] addr, logic [7:0] wdata,
		logic sdi);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, sdi, wdata, addr, go};
		do @(posedge clk); while (!s_tready);
	endtask

	// sda_in comes in runs of one level, long runs let acknowledges time out
	task automatic random_ticks(int n);
		logic sdi_lvl;
		logic sdi;
		int   run_left;
		run_left = 0;
		sdi_lvl = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				sdi_lvl = 1'($urandom_range(0, 1));
				run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 300)
					: $urandom_range(1, 12);
			end
			run_left--;
			sdi = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : sdi_lvl;
			send_tick($urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sdi);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle lines, a write start, go while busy
		send_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b1);
		send_tick(1'b1, 1'b0, 8'hFF, 8'h00, 1'b1);
		send_tick(1'b1, 1'b1, 8'h00, 8'hFF, 1'b0);
		repeat (4) send_tick(1'b0, 1'b1, 8'hA5, 8'h5A, 1'b0);
		drain();

		// zero hold acts as one
		write_reg(REG_HOLD_TICKS, 32'd0);
		write_reg(REG_ACK_TIMEOUT, 32'd1);
		for (int i = 0; i < 16; i++) send_tick(i[0], i[1], 8'hFF, 8'hFF, i[2]);
		random_ticks(100);
		drain();

		// zero ack timeout wraps to 256 polls
		write_reg(REG_HOLD_TICKS, 32'd1);
		write_reg(REG_ACK_TIMEOUT, 32'd0);
		random_ticks(120);
		drain();

		write_reg(REG_HOLD_TICKS, 32'd2);
		write_reg(REG_ACK_TIMEOUT, 32'd3);
		stall_req = 1'b1;
		random_ticks(100);
		drain();

		write_reg(REG_HOLD_TICKS, 32'd3);
		write_reg(REG_ACK_TIMEOUT, 32'd255);
		random_ticks(60);
		drain();

		calm = 1'b1;
		write_reg(REG_HOLD_TICKS, 32'd65535);
		write_reg(REG_ACK_TIMEOUT, 32'd2);
		random_ticks(40);
		drain();

		if (fails == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
